@@ rtl/mva_pkg.sv @@
// ----------------------------------------------------------------------------
// mva_pkg
// Types and constants shared by the voice allocator and its checker.
// ----------------------------------------------------------------------------
package mva_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef enum logic {
        OP_NOTE_ON,
        OP_RELEASE
    } t_op;

    localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
    localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
    localparam logic [3:0] MSG_CONTROL    = 4'hb;
    localparam logic [6:0] CTL_ALL_SOUND  = 7'h78;
    localparam logic [6:0] CTL_MODE_FIRST = 7'h7c;
    localparam logic [6:0] FULL_VELOCITY  = 7'd127;
    localparam logic [5:0] MAX_RESULTS    = 6'd32;
    localparam logic [31:0] FADE_RESET    = 32'd24000;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

endpackage

@@ rtl/midi_voice_allocator.sv @@
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Voice table for MIDI channel messages: note on takes a voice, note off,
// all-sound-off and channel mode messages release voices, one result per voice change.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                               | tuser        | tlast
//  s       | in        | data_first, data_second, event_time | status_byte  | -
//  m       | out       | voice_slot, key_number, velocity_out| change_kind  | last_of_run
//  cfg     | in        | fade_samples (write only)           | -            | -
//
//  Note on and release: not ready for another message until one scan over the voice
//  memory, through a single read port, one 33-bit add/compare and one 32-bit compare,
//  has finished and its last result, if any, is loaded. Other messages are accepted and dropped.
//  Output stalls hold the scan only when a second result is ready to leave.
//  Reset clears held and used flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module midi_voice_allocator #(
    parameter int VOICE_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // data_first[6:0], data_second[13:7], event_time[45:14]
    input  logic [7:0]  i_s_tuser,   // status_byte[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // voice_slot[4:0], key_number[11:5], velocity_out[18:12]
    output logic [0:0]  o_m_tuser,   // change_kind[0]
    output logic        o_m_tlast
);
    import mva_pkg::*;

    localparam int AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic            r_all, n_all;
    logic [6:0]      r_key, n_key;
    logic [6:0]      r_vel, n_vel;
    logic [31:0]     r_now, n_now;
    logic [31:0]     r_fade;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_addr_done, n_addr_done;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_ridx, n_ridx;
    logic [6:0]      r_rd_key;
    logic [31:0]     r_rd_time;
    logic [VOICE_COUNT-1:0] r_held, n_held;
    logic [VOICE_COUNT-1:0] r_ever, n_ever;
    logic            r_a_found, n_a_found;
    logic [AW-1:0]   r_a_idx, n_a_idx;
    logic            r_b_found, n_b_found;
    logic [AW-1:0]   r_b_idx, n_b_idx;
    logic            r_hold_vld, n_hold_vld;
    logic [AW-1:0]   r_hold_slot, n_hold_slot;
    logic [6:0]      r_hold_key, n_hold_key;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_out_vld, n_out_vld;
    logic [4:0]      r_out_slot, n_out_slot;
    logic [6:0]      r_out_key, n_out_key;
    logic [6:0]      r_out_vel, n_out_vel;
    logic            r_out_kind, n_out_kind;
    logic            r_out_last, n_out_last;

    logic [38:0]     r_mem [VOICE_COUNT];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [38:0]     mem_wdata;
    logic            rd_en;

    logic [32:0]     fade_sum;
    logic            fade_ok;
    logic            rel_ok;
    logic            load_ok;
    logic            match;
    logic            take;
    logic            stall;
    logic            s_xfer;
    logic [3:0]      msg_type;
    logic [6:0]      in_d1;
    logic [AW-1:0]   pick;

    assign fade_sum = {1'b0, r_rd_time} + {1'b0, r_fade};
    assign fade_ok  = fade_sum < {1'b0, r_now};
    assign rel_ok   = r_rd_time <= r_now;
    assign load_ok  = !r_out_vld || i_m_tready;
    assign s_xfer   = i_s_tvalid && o_s_tready;
    assign msg_type = i_s_tuser[7:4];
    assign in_d1    = i_s_tdata[6:0];
    assign match    = r_pend && (r_op == OP_RELEASE) && r_held[r_ridx]
                      && (r_all || (r_rd_key == r_key));
    assign take     = match && (r_cnt < MAX_RESULTS);
    assign stall    = take && r_hold_vld && !load_ok;
    assign pick     = r_a_found ? r_a_idx : (r_b_found ? r_b_idx : '0);

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_vel, r_out_key, r_out_slot};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_all       = r_all;
        n_key       = r_key;
        n_vel       = r_vel;
        n_now       = r_now;
        n_addr      = r_addr;
        n_addr_done = r_addr_done;
        n_pend      = r_pend;
        n_ridx      = r_ridx;
        n_held      = r_held;
        n_ever      = r_ever;
        n_a_found   = r_a_found;
        n_a_idx     = r_a_idx;
        n_b_found   = r_b_found;
        n_b_idx     = r_b_idx;
        n_hold_vld  = r_hold_vld;
        n_hold_slot = r_hold_slot;
        n_hold_key  = r_hold_key;
        n_cnt       = r_cnt;
        n_out_vld   = r_out_vld;
        n_out_slot  = r_out_slot;
        n_out_key   = r_out_key;
        n_out_vel   = r_out_vel;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_ridx;
        mem_wdata   = {r_now, r_rd_key};
        rd_en       = 1'b0;

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_key       = in_d1;
                    n_vel       = i_s_tdata[13:7];
                    n_now       = i_s_tdata[45:14];
                    n_addr      = '0;
                    n_addr_done = 1'b0;
                    n_pend      = 1'b0;
                    n_a_found   = 1'b0;
                    n_b_found   = 1'b0;
                    n_hold_vld  = 1'b0;
                    n_cnt       = '0;
                    n_all       = 1'b0;
                    if (msg_type == MSG_NOTE_ON) begin
                        n_op    = OP_NOTE_ON;
                        n_state = ST_SCAN;
                    end else if (msg_type == MSG_NOTE_OFF) begin
                        n_op    = OP_RELEASE;
                        n_state = ST_SCAN;
                    end else if (msg_type == MSG_CONTROL &&
                                 (in_d1 == CTL_ALL_SOUND || in_d1 >= CTL_MODE_FIRST)) begin
                        n_op    = OP_RELEASE;
                        n_all   = 1'b1;
                        n_vel   = FULL_VELOCITY;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (take) begin
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_kind = KIND_RELEASE;
                            n_out_slot = 5'(r_hold_slot);
                            n_out_key  = r_hold_key;
                            n_out_vel  = r_vel;
                            n_out_last = 1'b0;
                        end
                        n_hold_vld  = 1'b1;
                        n_hold_slot = r_ridx;
                        n_hold_key  = r_rd_key;
                        n_cnt       = r_cnt + 6'd1;
                    end
                    if (match) begin
                        n_held[r_ridx] = 1'b0;
                        mem_we         = 1'b1;
                    end
                    if (r_pend && r_op == OP_NOTE_ON && !r_held[r_ridx]) begin
                        if (!r_a_found && (!r_ever[r_ridx] || fade_ok)) begin
                            n_a_found = 1'b1;
                            n_a_idx   = r_ridx;
                        end
                        if (!r_b_found && (!r_ever[r_ridx] || rel_ok)) begin
                            n_b_found = 1'b1;
                            n_b_idx   = r_ridx;
                        end
                    end
                    if (!r_addr_done) begin
                        rd_en  = 1'b1;
                        n_pend = 1'b1;
                        n_ridx = r_addr;
                        if (r_addr == AW'(VOICE_COUNT - 1)) begin
                            n_addr_done = 1'b1;
                        end else begin
                            n_addr = r_addr + AW'(1);
                        end
                    end else begin
                        n_pend = 1'b0;
                        if (!r_pend) begin
                            n_state = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (r_op == OP_RELEASE && !r_hold_vld) begin
                    n_state = ST_IDLE;
                end else if (load_ok) begin
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    n_out_vel  = r_vel;
                    n_state    = ST_IDLE;
                    if (r_op == OP_RELEASE) begin
                        n_out_kind = KIND_RELEASE;
                        n_out_slot = 5'(r_hold_slot);
                        n_out_key  = r_hold_key;
                        n_hold_vld = 1'b0;
                    end else begin
                        n_out_kind   = KIND_START;
                        n_out_slot   = 5'(pick);
                        n_out_key    = r_key;
                        n_held[pick] = 1'b1;
                        n_ever[pick] = 1'b1;
                        mem_we       = 1'b1;
                        mem_waddr    = pick;
                        mem_wdata    = {r_now, r_key};
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_held     <= '0;
            r_ever     <= '0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_pend     <= 1'b0;
            r_fade     <= FADE_RESET;
        end else begin
            r_state    <= n_state;
            r_held     <= n_held;
            r_ever     <= n_ever;
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
            r_pend     <= n_pend;
            if (i_cfg_we) begin
                r_fade <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_all       <= n_all;
        r_key       <= n_key;
        r_vel       <= n_vel;
        r_now       <= n_now;
        r_addr      <= n_addr;
        r_addr_done <= n_addr_done;
        r_ridx      <= n_ridx;
        r_a_found   <= n_a_found;
        r_a_idx     <= n_a_idx;
        r_b_found   <= n_b_found;
        r_b_idx     <= n_b_idx;
        r_hold_slot <= n_hold_slot;
        r_hold_key  <= n_hold_key;
        r_cnt       <= n_cnt;
        r_out_slot  <= n_out_slot;
        r_out_key   <= n_out_key;
        r_out_vel   <= n_out_vel;
        r_out_kind  <= n_out_kind;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key  <= r_mem[r_addr][6:0];
            r_rd_time <= r_mem[r_addr][38:7];
        end
    end

endmodule

@@ rtl/mva_checker.sv @@
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks on the voice allocator, bound into the allocator module.
// ----------------------------------------------------------------------------
module mva_checker #(
    parameter int VOICE_COUNT = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [0:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import mva_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_start_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser[0] == KIND_START) |-> o_m_tlast)
        else $error("voice start result not marked last");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (VOICE_COUNT >= 32) || (o_m_tdata[4:0] < 5'(VOICE_COUNT)))
        else $error("voice slot out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not idle after reset");

endmodule

bind midi_voice_allocator mva_checker #(.VOICE_COUNT(VOICE_COUNT)) u_mva_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
